@@ rtl/lcdw_pkg.sv @@
package lcdw_pkg;

    localparam int MAX_COLUMNS_N = 40;
    localparam int MAX_ROWS_N    = 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [5:0] MAX_COLUMNS = 6'(MAX_COLUMNS_N);
    localparam logic [2:0] MAX_ROWS    = 3'(MAX_ROWS_N);

    localparam logic [2:0] OP_PRINT   = 3'd0;
    localparam logic [2:0] OP_SETPOS  = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_RAW_CMD = 3'd3;
    localparam logic [2:0] OP_RAW_DAT = 3'd4;

    localparam logic [2:0] CFG_COLUMNS = 3'd0;
    localparam logic [2:0] CFG_ROWS    = 3'd1;
    localparam logic [2:0] CFG_BASE0   = 3'd2;
    localparam logic [2:0] CFG_BASE1   = 3'd3;
    localparam logic [2:0] CFG_BASE2   = 3'd4;
    localparam logic [2:0] CFG_BASE3   = 3'd5;

    localparam logic [5:0] RST_COLUMNS = 6'd16;
    localparam logic [2:0] RST_ROWS    = 3'd2;
    localparam logic [6:0] RST_BASE0   = 7'd0;
    localparam logic [6:0] RST_BASE1   = 7'd64;
    localparam logic [6:0] RST_BASE2   = 7'd16;
    localparam logic [6:0] RST_BASE3   = 7'd80;

    localparam logic [7:0] NIB_MASK    = 8'hF0;
    localparam logic [7:0] CODE_CR     = 8'd13;
    localparam logic [7:0] CODE_LF     = 8'd10;
    localparam logic [7:0] CODE_LOWEST = 8'd10;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_SETPOS  = 8'h80;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef struct packed {
        logic       rs0;
        logic [7:0] byte0;
        logic       rs1;
        logic [7:0] byte1;
        logic       two;
    } job_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

    function automatic logic [7:0] setpos_byte(input logic [6:0] base, input logic [5:0] col);
        logic [6:0] addr;
        addr = base | {1'b0, col};
        return CMD_SETPOS | {1'b0, addr};
    endfunction

endpackage

@@ rtl/character_lcd_cursor_writer_unit.sv @@
// Cursor writer for a character display on a 4-bit bus.
// Input channel (in_valid / in_stall) carries one request: opcode, char_code,
// column_pos, row_pos. A request turns into zero to four nibble strobes on the
// output channel (out_valid / out_stall): register_select, bus_nibble and
// last_of_run, which marks the final nibble of a request.
// The front stage keeps the cursor, classifies the request and takes one request
// per cycle while its two-entry job queue has room; in_stall is the queue full.
// The back stage sends nibbles from the queue head into an output register.
// Sustained rate is one nibble per cycle while out_stall is low, set by the
// single nibble output. While out_valid and out_stall are high the output
// register holds and the back stage waits; the front keeps accepting until
// the queue fills, then raises in_stall. The user must write configuration
// through cfg_we / cfg_index / cfg_data only while idle; the block itself
// does not enforce this.
// Reset clears the cursor to row 0, column 0, empties the queue, drops out_valid
// and loads the default geometry: 16 columns, 2 rows, row bases 0, 64, 16, 80.
module character_lcd_cursor_writer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] opcode,
    input  logic [7:0] char_code,
    input  logic [5:0] column_pos,
    input  logic [1:0] row_pos,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       register_select,
    output logic [3:0] bus_nibble,
    output logic       last_of_run
);

    lcdw_pkg::q_status_t q_status;
    lcdw_pkg::job_t      push_job;
    lcdw_pkg::job_t      head_job;
    logic                push;
    logic                pop;

    lcdw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .char_code  (char_code),
        .column_pos (column_pos),
        .row_pos    (row_pos),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    lcdw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_status (q_status),
        .head_job (head_job)
    );

    lcdw_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_status        (q_status),
        .head_job        (head_job),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .register_select (register_select),
        .bus_nibble      (bus_nibble),
        .last_of_run     (last_of_run)
    );

endmodule

@@ rtl/lcdw_front.sv @@
module lcdw_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic [7:0]          char_code,
    input  logic [5:0]          column_pos,
    input  logic [1:0]          row_pos,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    input  lcdw_pkg::q_status_t q_status,
    output logic                push,
    output lcdw_pkg::job_t      push_job
);

    logic [5:0] columns_reg;
    logic [2:0] rows_reg;
    logic [6:0] base0_reg;
    logic [6:0] base1_reg;
    logic [6:0] base2_reg;
    logic [6:0] base3_reg;
    logic [2:0] row_reg;
    logic [2:0] row_next;
    logic [5:0] col_reg;
    logic [5:0] col_next;

    logic           fire;
    logic           has_job;
    lcdw_pkg::job_t job;
    logic [5:0]     eff_cols;
    logic [2:0]     eff_rows;
    logic [2:0]     row_inc;
    logic [1:0]     tgt_row;
    logic [5:0]     tgt_col;
    logic [6:0]     tgt_base;
    logic [7:0]     sp_byte;

    assign in_stall = q_status.full;
    assign fire     = in_valid && !q_status.full;
    assign push     = fire && has_job;
    assign push_job = job;

    assign eff_cols = (columns_reg > lcdw_pkg::MAX_COLUMNS) ? lcdw_pkg::MAX_COLUMNS : columns_reg;
    assign eff_rows = (rows_reg > lcdw_pkg::MAX_ROWS) ? lcdw_pkg::MAX_ROWS : rows_reg;
    assign row_inc  = row_reg + 3'd1;

    always_comb
    begin
        if (opcode == lcdw_pkg::OP_SETPOS)
        begin
            tgt_row = row_pos;
            tgt_col = column_pos;
        end
        else if (char_code == lcdw_pkg::CODE_CR)
        begin
            tgt_row = row_reg[1:0];
            tgt_col = 6'd0;
        end
        else
        begin
            tgt_row = row_inc[1:0];
            tgt_col = 6'd0;
        end
    end

    always_comb
    begin
        case (tgt_row)
            2'd0:    tgt_base = base0_reg;
            2'd1:    tgt_base = base1_reg;
            2'd2:    tgt_base = base2_reg;
            default: tgt_base = base3_reg;
        endcase
    end

    assign sp_byte = lcdw_pkg::setpos_byte(tgt_base, tgt_col);

    always_comb
    begin
        job      = '0;
        has_job  = 1'b0;
        row_next = row_reg;
        col_next = col_reg;
        unique case (opcode)
            lcdw_pkg::OP_PRINT:
            begin
                if (char_code < lcdw_pkg::CODE_LOWEST)
                begin
                    has_job = 1'b0;
                end
                else if (char_code == lcdw_pkg::CODE_CR)
                begin
                    col_next = 6'd0;
                    if (row_reg < eff_rows)
                    begin
                        has_job   = 1'b1;
                        job.rs0   = lcdw_pkg::RS_CMD;
                        job.byte0 = sp_byte;
                    end
                end
                else if (char_code == lcdw_pkg::CODE_LF || col_reg >= eff_cols)
                begin
                    has_job = 1'b1;
                    if (row_inc < eff_rows)
                    begin
                        row_next  = row_inc;
                        job.rs0   = lcdw_pkg::RS_CMD;
                        job.byte0 = sp_byte;
                        if (char_code == lcdw_pkg::CODE_LF)
                        begin
                            col_next = 6'd0;
                        end
                        else
                        begin
                            col_next  = 6'd1;
                            job.rs1   = lcdw_pkg::RS_DATA;
                            job.byte1 = char_code;
                            job.two   = 1'b1;
                        end
                    end
                    else
                    begin
                        row_next  = 3'd0;
                        col_next  = 6'd0;
                        job.rs0   = lcdw_pkg::RS_CMD;
                        job.byte0 = lcdw_pkg::CMD_CLEAR;
                        job.rs1   = lcdw_pkg::RS_CMD;
                        job.byte1 = lcdw_pkg::CMD_HOME;
                        job.two   = 1'b1;
                    end
                end
                else
                begin
                    has_job   = 1'b1;
                    col_next  = col_reg + 6'd1;
                    job.rs0   = lcdw_pkg::RS_DATA;
                    job.byte0 = char_code;
                end
            end
            lcdw_pkg::OP_SETPOS:
            begin
                row_next = {1'b0, row_pos};
                col_next = column_pos;
                if ({1'b0, row_pos} < eff_rows)
                begin
                    has_job   = 1'b1;
                    job.rs0   = lcdw_pkg::RS_CMD;
                    job.byte0 = sp_byte;
                end
            end
            lcdw_pkg::OP_CLEAR:
            begin
                has_job   = 1'b1;
                row_next  = 3'd0;
                col_next  = 6'd0;
                job.rs0   = lcdw_pkg::RS_CMD;
                job.byte0 = lcdw_pkg::CMD_CLEAR;
                job.rs1   = lcdw_pkg::RS_CMD;
                job.byte1 = lcdw_pkg::CMD_HOME;
                job.two   = 1'b1;
            end
            lcdw_pkg::OP_RAW_CMD:
            begin
                has_job   = 1'b1;
                job.rs0   = lcdw_pkg::RS_CMD;
                job.byte0 = char_code;
            end
            lcdw_pkg::OP_RAW_DAT:
            begin
                has_job   = 1'b1;
                job.rs0   = lcdw_pkg::RS_DATA;
                job.byte0 = char_code;
            end
            default:
            begin
                has_job = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 3'd0;
            col_reg <= 6'd0;
        end
        else if (fire)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= lcdw_pkg::RST_COLUMNS;
            rows_reg    <= lcdw_pkg::RST_ROWS;
            base0_reg   <= lcdw_pkg::RST_BASE0;
            base1_reg   <= lcdw_pkg::RST_BASE1;
            base2_reg   <= lcdw_pkg::RST_BASE2;
            base3_reg   <= lcdw_pkg::RST_BASE3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcdw_pkg::CFG_COLUMNS: columns_reg <= cfg_data[5:0];
                lcdw_pkg::CFG_ROWS:    rows_reg    <= cfg_data[2:0];
                lcdw_pkg::CFG_BASE0:   base0_reg   <= cfg_data;
                lcdw_pkg::CFG_BASE1:   base1_reg   <= cfg_data;
                lcdw_pkg::CFG_BASE2:   base2_reg   <= cfg_data;
                lcdw_pkg::CFG_BASE3:   base3_reg   <= cfg_data;
                default:               columns_reg <= columns_reg;
            endcase
        end
    end

endmodule

@@ rtl/lcdw_queue.sv @@
module lcdw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcdw_pkg::job_t      push_job,
    input  logic                pop,
    output lcdw_pkg::q_status_t q_status,
    output lcdw_pkg::job_t      head_job
);

    lcdw_pkg::job_t                    entry_reg [lcdw_pkg::QUEUE_DEPTH];
    logic [lcdw_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [lcdw_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [lcdw_pkg::QCNT_W-1:0]       count_reg;
    logic [lcdw_pkg::QCNT_W-1:0]       count_next;
    logic                              do_pop;

    assign q_status.full     = (count_reg == lcdw_pkg::QCNT_W'(lcdw_pkg::QUEUE_DEPTH));
    assign q_status.nonempty = (count_reg != '0);
    assign head_job          = entry_reg[rd_ptr_reg];
    assign do_pop            = pop && q_status.nonempty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == lcdw_pkg::QPTR_W'(lcdw_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == lcdw_pkg::QPTR_W'(lcdw_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

@@ rtl/lcdw_back.sv @@
module lcdw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lcdw_pkg::q_status_t q_status,
    input  lcdw_pkg::job_t      head_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                register_select,
    output logic [3:0]          bus_nibble,
    output logic                last_of_run
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       rs_reg;
    logic [3:0] nib_reg;
    logic       last_reg;

    logic       load;
    logic       is_last;
    logic [7:0] cur_byte;
    logic       cur_rs;
    logic [3:0] cur_nib;

    assign load     = !valid_reg || !out_stall;
    assign cur_byte = idx_reg[1] ? head_job.byte1 : head_job.byte0;
    assign cur_rs   = idx_reg[1] ? head_job.rs1 : head_job.rs0;
    assign cur_nib  = idx_reg[0] ? cur_byte[3:0] : 4'((cur_byte & lcdw_pkg::NIB_MASK) >> 4);
    assign is_last  = head_job.two ? (idx_reg == 2'd3) : (idx_reg == 2'd1);
    assign pop      = load && q_status.nonempty && is_last;

    assign out_valid       = valid_reg;
    assign register_select = rs_reg;
    assign bus_nibble      = nib_reg;
    assign last_of_run     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= q_status.nonempty;
            if (q_status.nonempty)
            begin
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && q_status.nonempty)
        begin
            rs_reg   <= cur_rs;
            nib_reg  <= cur_nib;
            last_reg <= is_last;
        end
    end

endmodule

@@ rtl/lcdw_checker.sv @@
module lcdw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       register_select,
    input logic [3:0] bus_nibble,
    input logic       last_of_run
);

    logic [1:0] cnt_reg;
    logic       rs_prev_reg;
    logic       out_fire;

    assign out_fire = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= 2'd0;
            rs_prev_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            cnt_reg     <= last_of_run ? 2'd0 : cnt_reg + 2'd1;
            rs_prev_reg <= register_select;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bus_nibble)
            && $stable(register_select) && $stable(last_of_run))
        else $error("stalled nibble changed");

    a_run_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && last_of_run |-> cnt_reg[0])
        else $error("request ended on a high nibble");

    a_byte_rs: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && cnt_reg[0] |-> register_select == rs_prev_reg)
        else $error("register select changed inside a byte");

    a_run_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && cnt_reg == 2'd3 |-> last_of_run)
        else $error("request produced more than four nibbles");

endmodule

bind character_lcd_cursor_writer_unit lcdw_checker u_lcdw_checker (.*);

@@ dv/character_lcd_cursor_writer_unit_tb.sv @@
module character_lcd_cursor_writer_unit_tb;

    localparam int HANG_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [2:0] OP_UNUSED_FIRST = lcdw_pkg::OP_RAW_DAT + 3'd1;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic [5:0] column_pos;
        logic [1:0] row_pos;
    } lcd_request_t;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } nibble_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] opcode = '0;
    logic [7:0] char_code = '0;
    logic [5:0] column_pos = '0;
    logic [1:0] row_pos = '0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [6:0] cfg_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       register_select;
    logic [3:0] bus_nibble;
    logic       last_of_run;

    character_lcd_cursor_writer_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .char_code       (char_code),
        .column_pos      (column_pos),
        .row_pos         (row_pos),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .register_select (register_select),
        .bus_nibble      (bus_nibble),
        .last_of_run     (last_of_run)
    );

    always #4 clk = ~clk;

    lcd_request_t pending_requests[$];
    lcd_request_t held_request;
    nibble_t      expected_nibbles[$];
    nibble_t      run_buf[4];
    nibble_t      seen_nibble;
    int           run_len;
    int           requests_queued;
    int           requests_taken = 0;
    int           send_idle_pct;
    int           stall_pct;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    logic [5:0] geo_cols;
    logic [2:0] geo_rows;
    logic [6:0] geo_base[4];
    logic [2:0] cur_row = '0;
    logic [5:0] cur_col = '0;

    function automatic logic [5:0] cols_limit();
        return (geo_cols > lcdw_pkg::MAX_COLUMNS) ? lcdw_pkg::MAX_COLUMNS : geo_cols;
    endfunction

    function automatic logic [2:0] rows_limit();
        return (geo_rows > lcdw_pkg::MAX_ROWS) ? lcdw_pkg::MAX_ROWS : geo_rows;
    endfunction

    task automatic queue_nibble(input logic rs, input logic [3:0] nib);
        if (run_len < 4)
        begin
            run_buf[run_len].rs   = rs;
            run_buf[run_len].nib  = nib;
            run_buf[run_len].last = 1'b0;
            run_len++;
        end
    endtask

    task automatic queue_byte(input logic rs, input logic [7:0] value);
        queue_nibble(rs, value[7:4]);
        queue_nibble(rs, value[3:0]);
    endtask

    task automatic model_clear();
        queue_byte(lcdw_pkg::RS_CMD, lcdw_pkg::CMD_CLEAR);
        queue_byte(lcdw_pkg::RS_CMD, lcdw_pkg::CMD_HOME);
        cur_row = '0;
        cur_col = '0;
    endtask

    task automatic model_goto(input logic [5:0] col, input logic [2:0] row);
        logic [6:0] addr;
        cur_row = row;
        cur_col = col;
        addr = geo_base[cur_row[1:0]] | {1'b0, cur_col};
        if (cur_row < rows_limit())
            queue_byte(lcdw_pkg::RS_CMD, lcdw_pkg::CMD_SETPOS | {1'b0, addr});
    endtask

    task automatic model_print(input logic [7:0] code);
        if (code < lcdw_pkg::CODE_LOWEST)
            return;
        if (code == lcdw_pkg::CODE_CR)
            model_goto('0, cur_row);
        else if (code == lcdw_pkg::CODE_LF)
        begin
            cur_row = cur_row + 3'd1;
            if (cur_row < rows_limit())
                model_goto('0, cur_row);
            else
                model_clear();
        end
        else if (cur_col < cols_limit())
        begin
            queue_byte(lcdw_pkg::RS_DATA, code);
            cur_col = cur_col + 6'd1;
        end
        else
        begin
            cur_row = cur_row + 3'd1;
            if (cur_row < rows_limit())
            begin
                model_goto('0, cur_row);
                queue_byte(lcdw_pkg::RS_DATA, code);
                cur_col = cur_col + 6'd1;
            end
            else
                model_clear();
        end
    endtask

    task automatic track_request(input lcd_request_t r);
        run_len = 0;
        case (r.opcode)
            lcdw_pkg::OP_PRINT:   model_print(r.char_code);
            lcdw_pkg::OP_SETPOS:  model_goto(r.column_pos, {1'b0, r.row_pos});
            lcdw_pkg::OP_CLEAR:   model_clear();
            lcdw_pkg::OP_RAW_CMD: queue_byte(lcdw_pkg::RS_CMD, r.char_code);
            lcdw_pkg::OP_RAW_DAT: queue_byte(lcdw_pkg::RS_DATA, r.char_code);
            default: ;
        endcase
        for (int i = 0; i < run_len; i++)
        begin
            if (i == run_len - 1)
                run_buf[i].last = 1'b1;
            expected_nibbles.push_back(run_buf[i]);
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_request(held_request);
                requests_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    held_request = pending_requests.pop_front();
                    in_valid   <= 1'b1;
                    opcode     <= held_request.opcode;
                    char_code  <= held_request.char_code;
                    column_pos <= held_request.column_pos;
                    row_pos    <= held_request.row_pos;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_nibbles.size() == 0)
                flag_mismatch($sformatf("unexpected nibble rs=%0d nib=%h last=%0d",
                                        register_select, bus_nibble, last_of_run));
            else
            begin
                seen_nibble = expected_nibbles.pop_front();
                if (register_select !== seen_nibble.rs)
                    flag_mismatch($sformatf("register_select %0d, want %0d",
                                            register_select, seen_nibble.rs));
                if (bus_nibble !== seen_nibble.nib)
                    flag_mismatch($sformatf("bus_nibble %h, want %h",
                                            bus_nibble, seen_nibble.nib));
                if (last_of_run !== seen_nibble.last)
                    flag_mismatch($sformatf("last_of_run %0d, want %0d",
                                            last_of_run, seen_nibble.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("character_lcd_cursor_writer_unit_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_request(input logic [2:0] op, input logic [7:0] code,
                                 input logic [5:0] col, input logic [1:0] row);
        lcd_request_t r;
        r.opcode     = op;
        r.char_code  = code;
        r.column_pos = col;
        r.row_pos    = row;
        pending_requests.push_back(r);
        requests_queued++;
    endtask

    function automatic lcd_request_t random_request();
        lcd_request_t r;
        int pick;
        int flavor;
        pick   = $urandom_range(99);
        flavor = $urandom_range(99);
        r.char_code  = 8'($urandom_range(255));
        r.column_pos = 6'($urandom_range(63));
        r.row_pos    = 2'($urandom_range(3));
        if (pick < 55)
        begin
            r.opcode = lcdw_pkg::OP_PRINT;
            if (flavor < 80)
                r.char_code = 8'($urandom_range(8'h7E, 8'h20));
            else if (flavor < 88)
                r.char_code = lcdw_pkg::CODE_CR;
            else if (flavor < 95)
                r.char_code = lcdw_pkg::CODE_LF;
        end
        else if (pick < 67)
        begin
            r.opcode = lcdw_pkg::OP_SETPOS;
            if (flavor < 60)
                r.column_pos = 6'($urandom_range(geo_cols));
        end
        else if (pick < 74)
            r.opcode = lcdw_pkg::OP_CLEAR;
        else if (pick < 84)
            r.opcode = lcdw_pkg::OP_RAW_CMD;
        else if (pick < 94)
            r.opcode = lcdw_pkg::OP_RAW_DAT;
        else
            r.opcode = lcdw_pkg::OP_RAW_DAT + 3'($urandom_range(3, 1));
        return r;
    endfunction

    // hold until every request is taken and every nibble seen, then let the block drain
    task automatic settle();
        while (requests_taken != requests_queued || expected_nibbles.size() != 0)
            @(negedge clk);
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [6:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            lcdw_pkg::CFG_COLUMNS: geo_cols = value[5:0];
            lcdw_pkg::CFG_ROWS:    geo_rows = value[2:0];
            lcdw_pkg::CFG_BASE0:   geo_base[0] = value;
            lcdw_pkg::CFG_BASE1:   geo_base[1] = value;
            lcdw_pkg::CFG_BASE2:   geo_base[2] = value;
            lcdw_pkg::CFG_BASE3:   geo_base[3] = value;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [6:0] cols, input logic [6:0] rows,
                                input logic [6:0] b0, input logic [6:0] b1,
                                input logic [6:0] b2, input logic [6:0] b3);
        put_reg(lcdw_pkg::CFG_COLUMNS, cols);
        put_reg(lcdw_pkg::CFG_ROWS, rows);
        put_reg(lcdw_pkg::CFG_BASE0, b0);
        put_reg(lcdw_pkg::CFG_BASE1, b1);
        put_reg(lcdw_pkg::CFG_BASE2, b2);
        put_reg(lcdw_pkg::CFG_BASE3, b3);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int send_pct, input int hold_pct);
        send_idle_pct = send_pct;
        stall_pct     = hold_pct;
        repeat (count)
        begin
            pending_requests.push_back(random_request());
            requests_queued++;
        end
        settle();
    endtask

    initial
    begin
        geo_cols    = lcdw_pkg::RST_COLUMNS;
        geo_rows    = lcdw_pkg::RST_ROWS;
        geo_base[0] = lcdw_pkg::RST_BASE0;
        geo_base[1] = lcdw_pkg::RST_BASE1;
        geo_base[2] = lcdw_pkg::RST_BASE2;
        geo_base[3] = lcdw_pkg::RST_BASE3;
        requests_queued = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_request(lcdw_pkg::OP_PRINT, 8'h48, '0, '0);
        queue_request(lcdw_pkg::OP_PRINT, 8'hFF, '0, '0);
        queue_request(lcdw_pkg::OP_PRINT, 8'h00, '0, '0);
        queue_request(lcdw_pkg::OP_PRINT, lcdw_pkg::CODE_LOWEST - 8'd1, '0, '0);
        queue_request(lcdw_pkg::OP_PRINT, lcdw_pkg::CODE_CR, '0, '0);
        queue_request(lcdw_pkg::OP_PRINT, lcdw_pkg::CODE_LF, '0, '0);
        queue_request(lcdw_pkg::OP_PRINT, lcdw_pkg::CODE_LF, '0, '0);
        queue_request(lcdw_pkg::OP_SETPOS, 8'h00, 6'd63, 2'd0);
        queue_request(lcdw_pkg::OP_PRINT, 8'h78, '0, '0);
        queue_request(lcdw_pkg::OP_SETPOS, 8'h00, 6'd16, 2'd1);
        queue_request(lcdw_pkg::OP_PRINT, 8'h79, '0, '0);
        queue_request(lcdw_pkg::OP_SETPOS, 8'hFF, 6'd5, 2'd3);
        queue_request(lcdw_pkg::OP_PRINT, lcdw_pkg::CODE_CR, '0, '0);
        queue_request(lcdw_pkg::OP_PRINT, 8'h7A, '0, '0);
        queue_request(lcdw_pkg::OP_CLEAR, 8'hFF, 6'd63, 2'd3);
        queue_request(lcdw_pkg::OP_RAW_CMD, 8'h00, '0, '0);
        queue_request(lcdw_pkg::OP_RAW_CMD, 8'hFF, '0, '0);
        queue_request(lcdw_pkg::OP_RAW_DAT, 8'hA5, '0, '0);
        queue_request(lcdw_pkg::OP_RAW_DAT, 8'h5A, '0, '0);
        queue_request(OP_UNUSED_FIRST, 8'hFF, 6'd63, 2'd3);
        queue_request(OP_UNUSED_FIRST + 3'd1, 8'h41, 6'd0, 2'd0);
        queue_request(OP_UNUSED_FIRST + 3'd2, 8'h41, 6'd21, 2'd2);
        queue_request(lcdw_pkg::OP_SETPOS, 8'h00, 6'd42, 2'd1);
        queue_request(lcdw_pkg::OP_PRINT, 8'h7E, '0, '0);
        settle();

        set_geometry(7'd40, 7'd4, 7'd0, 7'd64, 7'd20, 7'd84);
        run_phase(60, 0, 0);
        set_geometry(7'd1, 7'd1, 7'd127, 7'd127, 7'd127, 7'd127);
        run_phase(50, 71, 0);
        set_geometry(7'd63, 7'd7, 7'($urandom_range(127)), 7'($urandom_range(127)),
                     7'($urandom_range(127)), 7'($urandom_range(127)));
        run_phase(60, 0, 71);
        set_geometry(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
        run_phase(40, 23, 23);
        set_geometry(7'd20, 7'd4, 7'($urandom_range(127)), 7'($urandom_range(127)),
                     7'($urandom_range(127)), 7'($urandom_range(127)));
        run_phase(70, 71, 0);
        set_geometry(7'd8, 7'd3, 7'($urandom_range(127)), 7'($urandom_range(127)),
                     7'($urandom_range(127)), 7'($urandom_range(127)));
        run_phase(70, 23, 23);

        if (mismatches == 0)
            $display("character_lcd_cursor_writer_unit_tb: PASS");
        else
            $display("character_lcd_cursor_writer_unit_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lcdw_pkg.sv
rtl/lcdw_front.sv
rtl/lcdw_queue.sv
rtl/lcdw_back.sv
rtl/character_lcd_cursor_writer_unit.sv
rtl/lcdw_checker.sv
dv/character_lcd_cursor_writer_unit_tb.sv
